>>> rtl/addressed_frame_receiver_core_defines.svh
// Assertion macros for the addressed frame receiver.
// Depends on clk and arst_n being in scope where the macros are used.
`ifndef ADDRESSED_FRAME_RECEIVER_CORE_DEFINES_SVH
`define ADDRESSED_FRAME_RECEIVER_CORE_DEFINES_SVH

// Check that post holds in the same cycle as pre.
`define AFR_ASSERT_SAME(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("addressed frame receiver: same-cycle check failed");

// Check that post holds in the cycle after pre.
`define AFR_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("addressed frame receiver: next-cycle check failed");

`endif

>>> rtl/afr_pkg.sv
// Shared types and constants for the addressed frame receiver.
// Used by afr_deframer and addressed_frame_receiver_core; no dependencies.
package afr_pkg;

	localparam logic [7:0] BROADCAST_ADDR  = 8'd255;
	localparam logic [7:0] CMD_ECHO_A      = 8'd112;
	localparam logic [7:0] CMD_ECHO_B      = 8'd120;
	localparam logic [7:0] NODE_ADDR_RESET = 8'd7;
	localparam logic [1:0] GOOD_CNT_MAX    = 2'd3;
	localparam logic [1:0] GOOD_CNT_ECHO   = 2'd2;

	// Position of the next byte within a frame
	typedef enum logic [6:0] {
		PH_ADDR  = 7'b000_0001,
		PH_SEQ   = 7'b000_0010,
		PH_CMD   = 7'b000_0100,
		PH_CHAN  = 7'b000_1000,
		PH_SIZE  = 7'b001_0000,
		PH_VALUE = 7'b010_0000,
		PH_CHECK = 7'b100_0000
	} phase_t;

	typedef struct packed {
		logic       status;
		logic [7:0] frame_address;
		logic [7:0] frame_sequence;
		logic [7:0] frame_command;
		logic [7:0] frame_channel;
		logic [7:0] frame_size;
		logic [7:0] frame_value;
		logic [7:0] computed_check;
		logic       echo_request;
	} result_t;

	// What the deframer makes of the byte it is offered
	typedef struct packed {
		logic    fire;
		result_t res;
	} outcome_t;

endpackage

>>> rtl/afr_deframer.sv
// Frame state machine: holds the frame fields, checks the checksum, tracks echo state.
// Depends on afr_pkg.
module afr_deframer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        rx_byte,
	input  logic [7:0]        node_address,
	output afr_pkg::outcome_t outcome
);

	afr_pkg::phase_t phase_q, phase_d;
	logic [7:0] addr_q, seq_q, cmd_q, chan_q, size_q, value_q;
	logic       armed_q, armed_d;
	logic [1:0] good_q, good_d;
	logic [7:0] calc;
	logic       bad;
	logic       echo;
	logic       armed_set;
	logic [1:0] good_inc;

	// Checksum and echo decision for the byte at the checksum position
	always_comb begin
		calc      = ~(addr_q | seq_q | cmd_q | chan_q | size_q | value_q);
		bad       = (rx_byte != calc);
		armed_set = armed_q || (cmd_q == afr_pkg::CMD_ECHO_A) || (cmd_q == afr_pkg::CMD_ECHO_B);
		good_inc  = (good_q == afr_pkg::GOOD_CNT_MAX) ? good_q : good_q + 2'd1;
		echo      = 1'b0;
		armed_d   = armed_q;
		good_d    = good_q;
		if (!bad) begin
			armed_d = armed_set;
			good_d  = good_inc;
			if (armed_set && (good_inc == afr_pkg::GOOD_CNT_ECHO)) begin
				echo    = 1'b1;
				armed_d = 1'b0;
				good_d  = 2'd0;
			end
		end
	end

	// Next phase; an unexpected code is handled as the address position
	always_comb begin
		case (phase_q)
			afr_pkg::PH_SEQ:   phase_d = afr_pkg::PH_CMD;
			afr_pkg::PH_CMD:   phase_d = afr_pkg::PH_CHAN;
			afr_pkg::PH_CHAN:  phase_d = afr_pkg::PH_SIZE;
			afr_pkg::PH_SIZE:  phase_d = afr_pkg::PH_VALUE;
			afr_pkg::PH_VALUE: phase_d = afr_pkg::PH_CHECK;
			afr_pkg::PH_CHECK: phase_d = afr_pkg::PH_ADDR;
			default: begin
				if ((rx_byte == node_address) || (rx_byte == afr_pkg::BROADCAST_ADDR))
					phase_d = afr_pkg::PH_SEQ;
				else
					phase_d = afr_pkg::PH_ADDR;
			end
		endcase
	end

	// Advance control state on each consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= afr_pkg::PH_ADDR;
			armed_q <= 1'b0;
			good_q  <= 2'd0;
		end else if (step) begin
			phase_q <= phase_d;
			if (phase_q == afr_pkg::PH_CHECK) begin
				armed_q <= armed_d;
				good_q  <= good_d;
			end
		end
	end

	// Capture frame fields at their positions
	always_ff @(posedge clk) begin
		if (step) begin
			case (phase_q)
				afr_pkg::PH_SEQ:   seq_q   <= rx_byte;
				afr_pkg::PH_CMD:   cmd_q   <= rx_byte;
				afr_pkg::PH_CHAN:  chan_q  <= rx_byte;
				afr_pkg::PH_SIZE:  size_q  <= rx_byte;
				afr_pkg::PH_VALUE: value_q <= rx_byte;
				afr_pkg::PH_CHECK: ;
				default: begin
					if ((rx_byte == node_address) || (rx_byte == afr_pkg::BROADCAST_ADDR))
						addr_q <= rx_byte;
				end
			endcase
		end
	end

	// Result of the checksum byte
	always_comb begin
		outcome.fire               = (phase_q == afr_pkg::PH_CHECK);
		outcome.res.status         = bad;
		outcome.res.frame_address  = addr_q;
		outcome.res.frame_sequence = seq_q;
		outcome.res.frame_command  = cmd_q;
		outcome.res.frame_channel  = chan_q;
		outcome.res.frame_size     = size_q;
		outcome.res.frame_value    = value_q;
		outcome.res.computed_check = calc;
		outcome.res.echo_request   = echo;
	end

endmodule

>>> rtl/addressed_frame_receiver_core.sv
// Addressed frame receiver: one byte per cycle in, one result per seven-byte frame out.
// Depends on afr_pkg, afr_deframer and addressed_frame_receiver_core_defines.svh.
//
// Accepts one received byte per clock cycle while in_stall is low. A byte is registered,
// then consumed by the frame state machine; the checksum byte of a frame loads the
// result register, so a result is offered in the cycle after its checksum beat is
// consumed. Bytes that produce no result keep flowing while a result waits to be taken;
// only a checksum byte waits behind a full result register whose beat is stalled.
// node_address resets to 7 and should be written only while the receiver is idle.
`include "addressed_frame_receiver_core_defines.svh"

module addressed_frame_receiver_core (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	// byte input
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	// frame result
	output logic       out_valid,
	input  logic       out_stall,
	output logic       status,
	output logic [7:0] frame_address,
	output logic [7:0] frame_sequence,
	output logic [7:0] frame_command,
	output logic [7:0] frame_channel,
	output logic [7:0] frame_size,
	output logic [7:0] frame_value,
	output logic [7:0] computed_check,
	output logic       echo_request
);

	logic               [7:0] node_address_q;
	logic                     valid_s1;
	logic               [7:0] byte_s1;
	logic                     valid_s2;
	afr_pkg::result_t         res_s2;
	afr_pkg::outcome_t        outcome;
	logic                     s2_free;
	logic                     advance_s1;

	// Node address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			node_address_q <= afr_pkg::NODE_ADDR_RESET;
		else if (cfg_we)
			node_address_q <= cfg_wdata;
	end

	// Handshake: hold the byte only when its result cannot be stored
	assign s2_free    = !valid_s2 || !out_stall;
	assign advance_s1 = valid_s1 && (!outcome.fire || s2_free);
	assign in_stall   = valid_s1 && !advance_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			byte_s1 <= rx_byte;
	end

	afr_deframer u_deframer (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance_s1),
		.rx_byte      (byte_s1),
		.node_address (node_address_q),
		.outcome      (outcome)
	);

	// Result register: load on a checksum beat, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance_s1 && outcome.fire)
			valid_s2 <= 1'b1;
		else if (!out_stall)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && outcome.fire)
			res_s2 <= outcome.res;
	end

	assign out_valid      = valid_s2;
	assign status         = res_s2.status;
	assign frame_address  = res_s2.frame_address;
	assign frame_sequence = res_s2.frame_sequence;
	assign frame_command  = res_s2.frame_command;
	assign frame_channel  = res_s2.frame_channel;
	assign frame_size     = res_s2.frame_size;
	assign frame_value    = res_s2.frame_value;
	assign computed_check = res_s2.computed_check;
	assign echo_request   = res_s2.echo_request;

	// An echo is only requested for a frame with a matching checksum
	`AFR_ASSERT_SAME(echo_only_good_a, valid_s2 && res_s2.echo_request, !res_s2.status)
	// Input stalls only when a checksum byte waits behind a blocked result
	`AFR_ASSERT_SAME(stall_cause_a, in_stall, valid_s1 && outcome.fire && valid_s2 && out_stall)
	// A consumed checksum byte always shows up as a result next cycle
	`AFR_ASSERT_NEXT(result_loaded_a, advance_s1 && outcome.fire, valid_s2)

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for addressed_frame_receiver_core: drives received bytes and
// node address writes, predicts every frame result and checks it. Depends on afr_pkg.
module testbench;

	localparam int SETTLE_CYCLES = 6;

	// Predicts frame results from accepted bytes and checks what the block returns
	class frame_scoreboard;
		logic [7:0]        node_addr;
		afr_pkg::phase_t   ph;
		logic [7:0]        h_addr, h_seq, h_cmd, h_chan, h_size, h_value;
		logic              armed;
		logic [1:0]        good_cnt;
		afr_pkg::result_t  frame_q[$];
		int                mismatches, frames_ok, frames_bad, echoes, dropped;

		function new();
			node_addr = afr_pkg::NODE_ADDR_RESET;
			ph = afr_pkg::PH_ADDR;
			{h_addr, h_seq, h_cmd, h_chan, h_size, h_value} = '0;
			armed = 1'b0;
			good_cnt = '0;
			mismatches = 0;
			frames_ok = 0;
			frames_bad = 0;
			echoes = 0;
			dropped = 0;
		endfunction

		function void set_node(input logic [7:0] a);
			node_addr = a;
		endfunction

		function int pending();
			return frame_q.size();
		endfunction

		// Advance the deframer by one accepted byte
		function void note_byte(input logic [7:0] b);
			afr_pkg::result_t r;
			logic [7:0]       calc;
			case (ph)
				afr_pkg::PH_SEQ: begin
					h_seq = b;
					ph = afr_pkg::PH_CMD;
				end
				afr_pkg::PH_CMD: begin
					h_cmd = b;
					ph = afr_pkg::PH_CHAN;
				end
				afr_pkg::PH_CHAN: begin
					h_chan = b;
					ph = afr_pkg::PH_SIZE;
				end
				afr_pkg::PH_SIZE: begin
					h_size = b;
					ph = afr_pkg::PH_VALUE;
				end
				afr_pkg::PH_VALUE: begin
					h_value = b;
					ph = afr_pkg::PH_CHECK;
				end
				afr_pkg::PH_CHECK: begin
					ph = afr_pkg::PH_ADDR;
					calc = ~(h_addr | h_seq | h_cmd | h_chan | h_size | h_value);
					r.status = (b != calc);
					r.echo_request = 1'b0;
					if (!r.status) begin
						frames_ok++;
						if (h_cmd == afr_pkg::CMD_ECHO_A || h_cmd == afr_pkg::CMD_ECHO_B)
							armed = 1'b1;
						if (good_cnt != afr_pkg::GOOD_CNT_MAX)
							good_cnt++;
						if (armed && good_cnt == afr_pkg::GOOD_CNT_ECHO) begin
							r.echo_request = 1'b1;
							good_cnt = '0;
							armed = 1'b0;
							echoes++;
						end
					end else begin
						frames_bad++;
					end
					r.frame_address = h_addr;
					r.frame_sequence = h_seq;
					r.frame_command = h_cmd;
					r.frame_channel = h_chan;
					r.frame_size = h_size;
					r.frame_value = h_value;
					r.computed_check = calc;
					frame_q.push_back(r);
				end
				default: begin
					// address byte: keep ours and broadcast, drop the rest
					if (b == node_addr || b == afr_pkg::BROADCAST_ADDR) begin
						h_addr = b;
						ph = afr_pkg::PH_SEQ;
					end else begin
						ph = afr_pkg::PH_ADDR;
						dropped++;
					end
				end
			endcase
		endfunction

		task report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
			mismatches++;
			$display("%0t MISMATCH %s: got %02h expected %02h", $realtime, what, got, want);
		endtask

		task compare_field(input string what, input logic [7:0] got, input logic [7:0] want);
			if (got !== want)
				report_mismatch(what, got, want);
		endtask

		// Compare one accepted result beat with the oldest predicted frame
		task check_result(input afr_pkg::result_t got);
			afr_pkg::result_t want;
			if (frame_q.size() == 0) begin
				report_mismatch("result beat with no frame pending", got.frame_address, 8'h00);
			end else begin
				want = frame_q.pop_front();
				compare_field("status", {7'd0, got.status}, {7'd0, want.status});
				compare_field("frame_address", got.frame_address, want.frame_address);
				compare_field("frame_sequence", got.frame_sequence, want.frame_sequence);
				compare_field("frame_command", got.frame_command, want.frame_command);
				compare_field("frame_channel", got.frame_channel, want.frame_channel);
				compare_field("frame_size", got.frame_size, want.frame_size);
				compare_field("frame_value", got.frame_value, want.frame_value);
				compare_field("computed_check", got.computed_check, want.computed_check);
				compare_field("echo_request", {7'd0, got.echo_request},
					{7'd0, want.echo_request});
			end
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'h00;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       status;
	logic [7:0] frame_address, frame_sequence, frame_command, frame_channel;
	logic [7:0] frame_size, frame_value, computed_check;
	logic       echo_request;

	frame_scoreboard  sb = new();
	afr_pkg::result_t seen_result;
	int               send_idle_pct = 0;
	int               recv_stall_pct = 0;
	int               hold_cycles = 0;
	int               bytes_sent = 0;
	logic [7:0]       rand_node;

	addressed_frame_receiver_core DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.frame_address  (frame_address),
		.frame_sequence (frame_sequence),
		.frame_command  (frame_command),
		.frame_channel  (frame_channel),
		.frame_size     (frame_size),
		.frame_value    (frame_value),
		.computed_check (computed_check),
		.echo_request   (echo_request)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Take result beats, then pick the next stall; a hold-off overrides the random stall
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			seen_result.status = status;
			seen_result.frame_address = frame_address;
			seen_result.frame_sequence = frame_sequence;
			seen_result.frame_command = frame_command;
			seen_result.frame_channel = frame_channel;
			seen_result.frame_size = frame_size;
			seen_result.frame_value = frame_value;
			seen_result.computed_check = computed_check;
			seen_result.echo_request = echo_request;
			sb.check_result(seen_result);
		end
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles = hold_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Offer one byte after a random gap and hold it until accepted
	task automatic send_byte(input logic [7:0] b);
		int gap = 0;
		while (gap < 20 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic [7:0] addr, input logic [7:0] seq,
			input logic [7:0] cmd, input logic [7:0] chan, input logic [7:0] size,
			input logic [7:0] value, input logic corrupt);
		logic [7:0] ck;
		ck = ~(addr | seq | cmd | chan | size | value);
		if (corrupt)
			ck = ck ^ 8'($urandom_range(255, 1));
		send_byte(addr);
		send_byte(seq);
		send_byte(cmd);
		send_byte(chan);
		send_byte(size);
		send_byte(value);
		send_byte(ck);
	endtask

	function automatic logic [7:0] pick_field();
		case ($urandom_range(4))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'($urandom_range(255));
			default: return 8'($urandom & $urandom & $urandom);
		endcase
	endfunction

	// Mostly well-formed frames; some noise bytes and cut-off frames in front
	task automatic random_frame(input int echo_pct);
		logic [7:0] addr, cmd;
		int         n;
		if ($urandom_range(99) < 15) begin
			n = $urandom_range(3, 1);
			repeat (n) send_byte(8'($urandom_range(255)));
		end
		addr = ($urandom_range(1)) ? afr_pkg::BROADCAST_ADDR : sb.node_addr;
		if ($urandom_range(99) < 10) begin
			send_byte(addr);
			n = $urandom_range(5, 1);
			repeat (n) send_byte(pick_field());
		end
		if ($urandom_range(99) < echo_pct)
			cmd = ($urandom_range(1)) ? afr_pkg::CMD_ECHO_A : afr_pkg::CMD_ECHO_B;
		else
			cmd = pick_field();
		send_frame(addr, pick_field(), cmd, pick_field(), pick_field(), pick_field(),
			$urandom_range(99) < 25);
	endtask

	// Stop sending and let every predicted result come back, then let the pipe settle
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_node_address(input logic [7:0] a);
		cfg_we <= 1'b1;
		cfg_wdata <= a;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_node(a);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: foreign address, broadcast arm, echo on node address, all-ones error
		send_byte(8'h00);
		send_frame(afr_pkg::BROADCAST_ADDR, 8'h00, afr_pkg::CMD_ECHO_A, 8'h00, 8'h00,
			8'h00, 1'b0);
		send_frame(afr_pkg::NODE_ADDR_RESET, 8'h80, afr_pkg::CMD_ECHO_B, 8'h01, 8'h00,
			8'h00, 1'b0);
		send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		drain_results();

		// Sender idles lightly, receiver heavily
		write_node_address(8'h00);
		send_idle_pct = 29;
		recv_stall_pct = 70;
		while (bytes_sent < 330) random_frame(85);
		drain_results();

		// Roles swapped, node address equal to broadcast
		write_node_address(8'hFF);
		send_idle_pct = 70;
		recv_stall_pct = 29;
		while (bytes_sent < 640) random_frame(85);
		drain_results();

		// No idling; first a long receiver hold-off that backs up the input
		rand_node = 8'($urandom_range(254, 1));
		write_node_address(rand_node);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 300;
		repeat (12) random_frame(20);
		drain_results();
		while (bytes_sent < 960) random_frame(20);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d bytes: %0d good frames, %0d checksum errors, %0d echoes,",
			bytes_sent, sb.frames_ok, sb.frames_bad, sb.echoes);
		$display("%0d dropped address bytes, node addresses 7, 0, 255 and %0d.",
			sb.dropped, rand_node);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("addressed_frame_receiver_core test passed");
		end else begin
			$display("addressed_frame_receiver_core test failed");
		end
		$finish;
	end

	// Watchdog for a hung handshake
	initial begin
		#2000000;
		$display("addressed_frame_receiver_core test failed");
		$finish;
	end

endmodule
